// ----- rtl/core/mi3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants of the 3x3 matrix inverse: item layouts, the
// job that travels from the cofactor front end to the divider back end, and
// the state carried through the divider pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // Element and matrix geometry.
  localparam int ELEM_W   = 32;
  localparam int NUM_ELEM = 9;
  localparam int IDX_W    = $clog2(NUM_ELEM);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEM - 1);

  // Exact integer widths of the adjugate arithmetic.
  localparam int PROD_W = 2 * ELEM_W;       // element times element
  localparam int COF_W  = PROD_W + 1;       // signed cofactor
  localparam int CMAG_W = PROD_W;           // cofactor magnitude, at most 2^63
  localparam int LO_W   = COF_W - ELEM_W;   // unsigned low slice of a cofactor
  localparam int LOPP_W = LO_W + 1 + ELEM_W;
  localparam int DET_W  = 98;               // signed determinant and its terms
  localparam int DMAG_W = DET_W - 1;        // determinant magnitude
  localparam int QUO_W  = ELEM_W;           // quotient bits produced per division

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Cofactor k of the inverse is m[a]*m[b] - m[c]*m[d], column-major indexes.
  typedef logic [IDX_W-1:0] idx_t;
  localparam idx_t COF_IDX [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd7, 4'd2, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd4, 4'd2},
    '{4'd6, 4'd5, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd6, 4'd2}, '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  // Input item: one matrix, column-major.
  typedef struct packed {
    logic signed [ELEM_W-1:0] in_r0c0;
    logic signed [ELEM_W-1:0] in_r1c0;
    logic signed [ELEM_W-1:0] in_r2c0;
    logic signed [ELEM_W-1:0] in_r0c1;
    logic signed [ELEM_W-1:0] in_r1c1;
    logic signed [ELEM_W-1:0] in_r2c1;
    logic signed [ELEM_W-1:0] in_r0c2;
    logic signed [ELEM_W-1:0] in_r1c2;
    logic signed [ELEM_W-1:0] in_r2c2;
  } in_item_t;

  // Result item: the inverse and its status flags.
  typedef struct packed {
    logic signed [ELEM_W-1:0] out_r0c0;
    logic signed [ELEM_W-1:0] out_r1c0;
    logic signed [ELEM_W-1:0] out_r2c0;
    logic signed [ELEM_W-1:0] out_r0c1;
    logic signed [ELEM_W-1:0] out_r1c1;
    logic signed [ELEM_W-1:0] out_r2c1;
    logic signed [ELEM_W-1:0] out_r0c2;
    logic signed [ELEM_W-1:0] out_r1c2;
    logic signed [ELEM_W-1:0] out_r2c2;
    logic                     singular;
    logic                     overflow;
  } out_item_t;

  // Classified matrix, ready for division.
  typedef struct packed {
    logic [NUM_ELEM-1:0][CMAG_W-1:0] cof_mag;
    logic [NUM_ELEM-1:0]             cof_neg;
    logic [DMAG_W-1:0]               det_mag;
    logic                            det_neg;
    logic                            singular;
  } job_t;

  // Per-division status that rides along the divider.
  typedef struct packed {
    logic neg;
    logic ovf;
    logic singular;
  } div_tag_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [DMAG_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
    logic [DMAG_W-1:0] den;
    div_tag_t          tag;
  } div_stage_t;

endpackage

// ----- rtl/core/mi3_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front
// Front end: a five-stage pipeline that takes one matrix per cycle unless
// stalled; forms the nine cofactors and exact determinant and classifies.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mi3_pkg::in_item_t in_data_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output mi3_pkg::job_t     job_o
);
  import mi3_pkg::*;

  logic signed [ELEM_W-1:0] m [NUM_ELEM];
  logic                     en;
  logic [4:0]               v_q;

  logic signed [PROD_W-1:0] s1_pa_q [NUM_ELEM];
  logic signed [PROD_W-1:0] s1_pb_q [NUM_ELEM];
  logic signed [ELEM_W-1:0] s1_e_q  [3];
  logic signed [COF_W-1:0]  s2_cof_q [NUM_ELEM];
  logic signed [ELEM_W-1:0] s2_e_q  [3];
  logic signed [LOPP_W-1:0] s3_lo_q [3];
  logic signed [PROD_W-1:0] s3_hi_q [3];
  logic signed [COF_W-1:0]  s3_cof_q [NUM_ELEM];
  logic signed [DET_W-1:0]  s4_term_q [3];
  logic signed [COF_W-1:0]  s4_cof_q [NUM_ELEM];
  logic signed [DET_W-1:0]  s5_det_q;
  logic signed [COF_W-1:0]  s5_cof_q [NUM_ELEM];
  logic signed [DET_W-1:0]  det_abs;
  logic signed [COF_W-1:0]  cof_abs [NUM_ELEM];

  // Unpack the matrix into column-major order.
  assign m[0] = in_data_i.in_r0c0;
  assign m[1] = in_data_i.in_r1c0;
  assign m[2] = in_data_i.in_r2c0;
  assign m[3] = in_data_i.in_r0c1;
  assign m[4] = in_data_i.in_r1c1;
  assign m[5] = in_data_i.in_r2c1;
  assign m[6] = in_data_i.in_r0c2;
  assign m[7] = in_data_i.in_r1c2;
  assign m[8] = in_data_i.in_r2c2;

  // The whole pipeline moves unless a finished job waits on a full queue.
  assign en         = !(v_q[4] && !job_ready_i);
  assign in_ready_o = en;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  // Stage 1: the eighteen element products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        s1_pa_q[k] <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
        s1_pb_q[k] <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) begin
        s1_e_q[j] <= m[3*j];
      end
    end
  end

  // Stage 2: cofactors.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        s2_cof_q[k] <= COF_W'(s1_pa_q[k]) - COF_W'(s1_pb_q[k]);
      end
      s2_e_q <= s1_e_q;
    end
  end

  // Stage 3: determinant partial products, cofactor split in two slices.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s3_lo_q[j] <= $signed({1'b0, s2_cof_q[j][LO_W-1:0]}) * s2_e_q[j];
        s3_hi_q[j] <= $signed(s2_cof_q[j][COF_W-1:LO_W]) * s2_e_q[j];
      end
      s3_cof_q <= s2_cof_q;
    end
  end

  // Stage 4: recombine the slices into the three determinant terms.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s4_term_q[j] <= (DET_W'(s3_hi_q[j]) <<< LO_W) + DET_W'(s3_lo_q[j]);
      end
      s4_cof_q <= s3_cof_q;
    end
  end

  // Stage 5: determinant.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_det_q <= s4_term_q[0] + s4_term_q[1] + s4_term_q[2];
      s5_cof_q <= s4_cof_q;
    end
  end

  // Classify: signs, magnitudes and the singular case.
  always_comb begin
    det_abs = s5_det_q[DET_W-1] ? -s5_det_q : s5_det_q;
    for (int k = 0; k < NUM_ELEM; k++) begin
      cof_abs[k]          = s5_cof_q[k][COF_W-1] ? -s5_cof_q[k] : s5_cof_q[k];
      job_o.cof_mag[k]    = cof_abs[k][CMAG_W-1:0];
      job_o.cof_neg[k]    = s5_cof_q[k][COF_W-1];
    end
    job_o.det_mag  = det_abs[DMAG_W-1:0];
    job_o.det_neg  = s5_det_q[DET_W-1];
    job_o.singular = (s5_det_q == '0);
  end

  assign job_valid_o = v_q[4];

endmodule

// ----- rtl/core/mi3_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module mi3_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mi3_pkg::job_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mi3_pkg::job_t out_data_o
);
  import mi3_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              wr, rd;

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign wr          = in_valid_i && in_ready_o;
  assign rd          = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

endmodule

// ----- rtl/core/mi3_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider: one quotient bit per stage, one division
// entering per cycle. The whole pipeline holds while en_i is low.
// ----------------------------------------------------------------------------
module mi3_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                op_valid_i,
  input  mi3_pkg::div_stage_t op_i,
  output logic                res_valid_o,
  output mi3_pkg::div_stage_t res_o
);
  import mi3_pkg::*;

  div_stage_t       stg_q [QUO_W];
  logic [QUO_W-1:0] vld_q;

  // One restoring step: bring in the next numerator bit, subtract if it fits.
  function automatic div_stage_t div_step(div_stage_t s);
    logic [DMAG_W:0] sh;
    logic [DMAG_W:0] diff;
    div_stage_t      r;
    sh    = {s.rem, s.low[QUO_W-1]};
    diff  = sh - {1'b0, s.den};
    r     = s;
    r.low = s.low << 1;
    if (sh >= {1'b0, s.den}) begin
      r.rem = diff[DMAG_W-1:0];
      r.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = sh[DMAG_W-1:0];
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    div_stage_t stg_in;
    logic       vld_in;

    if (i == 0) begin : g_first
      assign stg_in = div_step(op_i);
      assign vld_in = op_valid_i;
    end else begin : g_next
      assign stg_in = div_step(stg_q[i-1]);
      assign vld_in = vld_q[i-1];
    end

    // Stage valid bit.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    // Stage data.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[i] <= stg_in;
      end
    end
  end

  assign res_valid_o = vld_q[QUO_W-1];
  assign res_o       = stg_q[QUO_W-1];

endmodule

// ----- rtl/core/mi3_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back
// Back end: issues the nine divisions of a job into the divider one per
// cycle unless stalled, saturates the quotients, gathers the result item.
// ----------------------------------------------------------------------------
module mi3_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  mi3_pkg::job_t      job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mi3_pkg::out_item_t out_data_o
);
  import mi3_pkg::*;

  localparam int NUM_W = CMAG_W + 2 * FRAC_BITS;
  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = (HI_W > DMAG_W) ? HI_W : DMAG_W;

  logic [IDX_W-1:0]  k_q;
  logic [NUM_W-1:0]  num;
  logic [HI_W-1:0]   num_hi;
  logic              ovf_pre;
  logic              issue;
  logic              stall;
  div_stage_t        op;
  logic              res_valid;
  div_stage_t        res;

  logic [IDX_W-1:0]  c_q;
  logic [ELEM_W-1:0] col_q [NUM_ELEM-1];
  logic              ovf_acc_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              out_free;
  logic              take;
  logic              load;
  logic [QUO_W-1:0]  lim;
  logic [QUO_W-1:0]  mag;
  logic              big;
  logic [ELEM_W-1:0] val;
  logic              eovf;
  logic              ovf_item;

  // Operand for element k: |cofactor| scaled by 2^(2*FRAC_BITS).
  always_comb begin
    num     = {job_i.cof_mag[k_q], {(2 * FRAC_BITS){1'b0}}};
    num_hi  = num[NUM_W-1:QUO_W];
    ovf_pre = CMP_W'(num_hi) >= CMP_W'(job_i.det_mag);
    op.rem  = ovf_pre ? '0 : DMAG_W'(num_hi);
    op.low  = num[QUO_W-1:0];
    op.quo  = '0;
    op.den  = job_i.det_mag;
    op.tag.neg      = job_i.cof_neg[k_q] ^ job_i.det_neg;
    op.tag.ovf      = ovf_pre;
    op.tag.singular = job_i.singular;
  end

  assign issue       = job_valid_i && !stall;
  assign job_ready_o = issue && (k_q == LAST_IDX);

  // Element counter of the job at the head of the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (issue) begin
      k_q <= (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
    end
  end

  mi3_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (!stall),
    .op_valid_i  (issue),
    .op_i        (op),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Saturate the quotient, apply the sign and zero a singular result.
  always_comb begin
    lim  = res.tag.neg ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
    big  = res.tag.ovf || (res.quo > lim);
    mag  = big ? lim : res.quo;
    val  = res.tag.singular ? '0 : (res.tag.neg ? (QUO_W'(0) - mag) : mag);
    eovf = big && !res.tag.singular;
  end

  // Collector handshake: the last element needs a free output register.
  assign out_free = !out_valid_q || out_ready_i;
  assign take     = res_valid && ((c_q != LAST_IDX) || out_free);
  assign stall    = res_valid && !take;
  assign load     = take && (c_q == LAST_IDX);
  assign ovf_item = ((c_q == '0) ? 1'b0 : ovf_acc_q) | eovf;

  // Collector count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        c_q <= (c_q == LAST_IDX) ? '0 : c_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Collector elements and overflow flag.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ovf_acc_q <= ovf_item;
      for (int j = 0; j < NUM_ELEM - 1; j++) begin
        if (c_q == IDX_W'(j)) begin
          col_q[j] <= val;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_r0c0 <= col_q[0];
      out_q.out_r1c0 <= col_q[1];
      out_q.out_r2c0 <= col_q[2];
      out_q.out_r0c1 <= col_q[3];
      out_q.out_r1c1 <= col_q[4];
      out_q.out_r2c1 <= col_q[5];
      out_q.out_r0c2 <= col_q[6];
      out_q.out_r1c2 <= col_q[7];
      out_q.out_r2c2 <= val;
      out_q.singular <= res.tag.singular;
      out_q.overflow <= ovf_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/matrix3x3_inverse.sv -----
`timescale 1ns / 1ps
// From the edge that accepts an item to result valid, the item passes the
// 4 cofactor stages after the first, the queue, 32 divider stages, the
// issue of the other eight elements and the output register.
// The single divider pipeline takes one of the nine divisions per cycle
// unless the collector stalls it. Up to one matrix per cycle is taken
// while the queue has room. Reset clears all valid bits and counters.
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Inverse of a 3x3 Q-format matrix by the adjugate: exact cofactors and
// determinant, truncating division, saturation and singular detection.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mi3_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mi3_pkg::out_item_t out_data_o
);
  import mi3_pkg::*;

  logic job_valid, job_ready;
  job_t job;
  logic q_valid, q_ready;
  job_t q_job;

  // Cofactors, determinant and classification.
  mi3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // Decoupling queue.
  mi3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (job_valid),
    .in_ready_o  (job_ready),
    .in_data_i   (job),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_job)
  );

  // Division, saturation and result assembly.
  mi3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
